// ===== rtl/dq_pkg.sv =====
package dq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int OCC_W    = 5;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_PEEK_REAR  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd6;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    DSEL_ZERO = 2'd0,
    DSEL_ONES = 2'd1,
    DSEL_MEM  = 2'd2
  } dsel_t;

  // Controller to datapath: one decoded transaction.
  typedef struct packed {
    logic    take;
    logic    write;
    logic    read;
    logic    rear;
    logic    remove;
    logic    clear;
    status_t status;
    dsel_t   dsel;
  } cmd_t;

  // Datapath to controller: occupancy flags before the action.
  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH words held in a ring buffer memory with
// a head index and an entry count. Each input transaction carries one action
// (push front/rear, pop front/rear, peek front/rear, clear) and produces exactly
// one result transaction in the next cycle: the removed or peeked word (-1 on an
// empty queue, 0 for other actions), a status code, empty/full flags and the
// occupancy after the action. A push on a full queue is dropped. The memory
// read is registered and holds the word for the result; with out_stall low one
// transaction is taken every cycle, and while a result is stalled the input is
// stalled too. Slots hold WORD_BITS bits; the data port shows them zero
// extended or truncated to 32 bits. No clearing pass runs after reset.
module double_ended_queue #(
  parameter int DEPTH     = dq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dq_pkg::ACTION_W-1:0]       action,
  input  logic signed [dq_pkg::VALUE_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dq_pkg::VALUE_W-1:0] data,
  output logic [1:0]                        status,
  output logic                              is_empty,
  output logic                              is_full,
  output logic [dq_pkg::OCC_W-1:0]          occupancy
);
  import dq_pkg::*;

  cmd_t       cmd;
  dp_status_t dps;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dps       (dps),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .dps       (dps),
    .data      (data),
    .status    (status),
    .is_empty  (is_empty),
    .is_full   (is_full),
    .occupancy (occupancy)
  );

endmodule

// ===== rtl/dq_ctrl.sv =====
module dq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dq_pkg::ACTION_W-1:0] action,
  output logic                        out_valid,
  input  logic                        out_stall,
  input  dq_pkg::dp_status_t          dps,
  output dq_pkg::cmd_t                cmd
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_RESULT = 2'b10
  } state_t;

  state_t state, state_next;
  logic   take;

  // Hold the input while a result is waiting and not being taken.
  assign in_stall  = (state == S_RESULT) && out_stall;
  assign out_valid = (state == S_RESULT);
  assign take      = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_stall && !take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.take   = take;
    cmd.status = ST_OK;
    cmd.dsel   = DSEL_ZERO;
    case (action)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (dps.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.write = take;
          cmd.rear  = (action == ACT_PUSH_REAR);
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
        if (dps.empty) begin
          cmd.status = ST_EMPTY;
          cmd.dsel   = DSEL_ONES;
        end else begin
          cmd.read   = take;
          cmd.dsel   = DSEL_MEM;
          cmd.rear   = (action == ACT_POP_REAR) || (action == ACT_PEEK_REAR);
          cmd.remove = take && ((action == ACT_POP_FRONT) || (action == ACT_POP_REAR));
        end
      end
      ACT_CLEAR: begin
        cmd.clear = take;
      end
      default: begin
      end
    endcase
  end

  a_take_result: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted transaction produced no result");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !dps.full)
    else $error("write issued on full queue");

  a_no_remove_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.remove || cmd.read) |-> !dps.empty)
    else $error("read issued on empty queue");

endmodule

// ===== rtl/dq_datapath.sv =====
module dq_datapath #(
  parameter int DEPTH     = dq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dq_pkg::cmd_t                      cmd,
  input  logic signed [dq_pkg::VALUE_W-1:0] value,
  output dq_pkg::dp_status_t                dps,
  output logic signed [dq_pkg::VALUE_W-1:0] data,
  output logic [1:0]                        status,
  output logic                              is_empty,
  output logic                              is_full,
  output logic [dq_pkg::OCC_W-1:0]          occupancy
);
  import dq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic [IDX_W-1:0]     head, head_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [IDX_W-1:0]     addr;
  logic [WORD_BITS-1:0] word;
  status_t              status_q;
  dsel_t                dsel_q;

  // Ring offset add: base < DEPTH and off <= DEPTH, so one subtract folds it.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
    return IDX_W'(sum);
  endfunction

  assign word      = WORD_BITS'($unsigned(value));
  assign dps.empty = (count == '0);
  assign dps.full  = (count == CNT_W'(DEPTH));

  always_comb begin
    if (cmd.write) begin
      addr = cmd.rear ? wrap_add(head, count) : wrap_add(head, CNT_W'(DEPTH - 1));
    end else begin
      addr = cmd.rear ? wrap_add(head, count - 1'b1) : head;
    end
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    if (cmd.clear) begin
      head_next  = '0;
      count_next = '0;
    end else if (cmd.write) begin
      if (!cmd.rear) head_next = addr;
      count_next = count + 1'b1;
    end else if (cmd.remove) begin
      if (!cmd.rear) head_next = wrap_add(head, CNT_W'(1));
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) mem[addr] <= word;
    if (cmd.read) rdata <= mem[addr];
  end

  // Hold the result payload from the accepting edge until the next transaction.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      status_q <= cmd.status;
      dsel_q   <= cmd.dsel;
    end
  end

  always_comb begin
    case (dsel_q)
      DSEL_MEM:  data = $signed(VALUE_W'(rdata));
      DSEL_ONES: data = $signed(VALUE_W'({WORD_BITS{1'b1}}));
      default:   data = '0;
    endcase
  end

  assign status    = status_q;
  assign is_empty  = dps.empty;
  assign is_full   = dps.full;
  assign occupancy = OCC_W'(count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.write && !cmd.clear) |=> (count == $past(count) + 1'b1))
    else $error("push did not advance the count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |=> (count == $past(count) - 1'b1))
    else $error("pop did not drop the count");

endmodule

// ===== tb/sv/tb_double_ended_queue.sv =====
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1230;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
  } dq_request_t;

  typedef struct {
    logic [VALUE_W-1:0] data;
    status_t            status;
    logic               empty;
    logic               full;
    logic [OCC_W-1:0]   occupancy;
  } dq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACTION_W-1:0] action = ACT_CLEAR;
  logic signed [VALUE_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VALUE_W-1:0] data;
  logic [1:0] status;
  logic is_empty;
  logic is_full;
  logic [OCC_W-1:0] occupancy;

  dq_request_t pending_requests[$];
  dq_result_t  expected_results[$];

  // Shadow copy of the ring buffer state.
  logic [VALUE_W-1:0] shadow_slots [RING_DEPTH];
  logic [3:0]         shadow_head = '0;
  logic [OCC_W-1:0]   shadow_count = '0;

  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int mon_cycle = 0;
  int hold_left = 0;

  double_ended_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .status    (status),
    .is_empty  (is_empty),
    .is_full   (is_full),
    .occupancy (occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_result(input logic [ACTION_W-1:0] act,
                                input logic [VALUE_W-1:0] val);
    dq_result_t r;
    logic [3:0] pos;
    r.data = '0;
    r.status = ST_OK;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (shadow_count >= RING_DEPTH) begin
          r.status = ST_FULL;
        end else if (act == ACT_PUSH_FRONT) begin
          shadow_head = shadow_head - 4'd1;
          shadow_slots[shadow_head] = val;
          shadow_count = shadow_count + 1'b1;
        end else begin
          pos = shadow_head + shadow_count[3:0];
          shadow_slots[pos] = val;
          shadow_count = shadow_count + 1'b1;
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
        if (shadow_count == 0) begin
          r.data = '1;
          r.status = ST_EMPTY;
        end else begin
          if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT)
            pos = shadow_head;
          else
            pos = shadow_head + shadow_count[3:0] - 4'd1;
          r.data = shadow_slots[pos];
          if (act == ACT_POP_FRONT) begin
            shadow_head = shadow_head + 4'd1;
            shadow_count = shadow_count - 1'b1;
          end else if (act == ACT_POP_REAR) begin
            shadow_count = shadow_count - 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        shadow_head = '0;
        shadow_count = '0;
      end
      default: ;
    endcase
    r.empty = (shadow_count == 0);
    r.full = (shadow_count == RING_DEPTH);
    r.occupancy = shadow_count;
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic add_request(input logic [ACTION_W-1:0] act,
                             input logic [VALUE_W-1:0] val);
    dq_request_t q;
    q.action = act;
    q.value = val;
    pending_requests.push_back(q);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(input int mode);
    int r;
    int push_pct;
    int pop_pct;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin push_pct = 70; pop_pct = 20; end
      1: begin push_pct = 20; pop_pct = 65; end
      2: begin push_pct = 40; pop_pct = 35; end
      default: begin push_pct = 30; pop_pct = 20; end
    endcase
    if (r < 2) return ACT_CLEAR;
    if (r < 4) return ACT_UNUSED;
    if (r < 4 + push_pct) return $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
    if (r < 4 + push_pct + pop_pct)
      return $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
    return $urandom_range(0, 1) ? ACT_PEEK_REAR : ACT_PEEK_FRONT;
  endfunction

  initial begin
    int mode;
    int len;
    int added;
    // Empty-queue reads, word extremes, last-entry removal from the rear.
    add_request(ACT_POP_FRONT, 32'h1234_5678);
    add_request(ACT_POP_REAR, 32'h0);
    add_request(ACT_PEEK_FRONT, 32'h0);
    add_request(ACT_PEEK_REAR, 32'h0);
    add_request(ACT_PUSH_FRONT, 32'h8000_0000);
    add_request(ACT_PUSH_REAR, 32'h7fff_ffff);
    add_request(ACT_PEEK_FRONT, 32'h0);
    add_request(ACT_PEEK_REAR, 32'h0);
    add_request(ACT_UNUSED, 32'hdead_beef);
    add_request(ACT_POP_REAR, 32'h0);
    add_request(ACT_POP_REAR, 32'h0);
    add_request(ACT_POP_REAR, 32'h0);
    add_request(ACT_PUSH_FRONT, 32'hffff_ffff);
    add_request(ACT_PUSH_FRONT, 32'h0000_0000);
    add_request(ACT_CLEAR, 32'h0);
    add_request(ACT_POP_FRONT, 32'h0);
    add_request(ACT_PUSH_REAR, 32'h5555_5555);
    add_request(ACT_PUSH_REAR, 32'haaaa_aaaa);
    add_request(ACT_POP_FRONT, 32'h0);
    add_request(ACT_POP_FRONT, 32'h0);
    add_request(ACT_POP_FRONT, 32'h0);
    // Random bursts that lean toward filling or draining so both limits are hit.
    added = 0;
    while (added < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(5, 40);
      for (int i = 0; i < len; i++) begin
        add_request(pick_action(mode), pick_value());
        added++;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver
  always @(posedge clk) begin : driver
    dq_request_t q;
    logic idle;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_result(action, value);
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        idle = (n_sent >= 500 && n_sent < 750) ? 1'b0 : ($urandom_range(0, 99) < 20);
        if (pending_requests.size() != 0 && !idle) begin
          q = pending_requests.pop_front();
          in_valid <= 1'b1;
          action <= q.action;
          value <= q.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin : monitor
    dq_result_t want;
    if (!rst) begin
      mon_cycle++;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none actual data %h status %h",
                   $time, data, status);
        end else begin
          want = expected_results.pop_front();
          check_field("data", want.data, data);
          check_field("status", 32'(want.status), 32'(status));
          check_field("is_empty", 32'(want.empty), 32'(is_empty));
          check_field("is_full", 32'(want.full), 32'(is_full));
          check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
          n_checked++;
        end
      end
      // Long hold-offs back the block up into its input.
      if (mon_cycle == 300 || mon_cycle == 1500)
        hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (n_checked >= 500 && n_checked < 750) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 20);
      end
    end
  end

  initial begin
    int guard;
    @(negedge rst);
    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    guard = 0;
    while (expected_results.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      n_errors++;
      $display("%0t: %0d results never arrived, expected %0d actual 0",
               $time, expected_results.size(), expected_results.size());
    end
    if (n_errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
